// ===== src/fnp_pkg.sv =====
package fnp_pkg;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	localparam logic [7:0] CHAR_GT  = 8'h3E;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_SP  = 8'h20;
	localparam logic [7:0] CHAR_TAB = 8'h09;

	localparam int RESULT_BASES_BITS  = 40;
	localparam int RESULT_NUMBER_BITS = 32;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]                          kind;
		logic [7:0]                          packed_byte;
		logic                                has_byte;
		logic [RESULT_BASES_BITS-1:0]        record_bases;
		logic [RESULT_NUMBER_BITS-1:0]       record_number;
		logic                                last_of_run;
	} out_item_t;

	// Case-insensitive IUPAC nucleotide code; anything unknown maps to N.
	function automatic logic [3:0] iupac_code(input logic [7:0] b);
		logic [7:0] u;
		logic [3:0] c;
		begin
			u = (b >= 8'h61 && b <= 8'h7A) ? (b - 8'h20) : b;
			case (u)
				8'h2D: c = 4'h0; // '-'
				8'h41: c = 4'h1; // A
				8'h43: c = 4'h2; // C
				8'h47: c = 4'h3; // G
				8'h54: c = 4'h4; // T
				8'h55: c = 4'h4; // U
				8'h52: c = 4'h5; // R
				8'h59: c = 4'h6; // Y
				8'h4D: c = 4'h7; // M
				8'h4B: c = 4'h8; // K
				8'h53: c = 4'h9; // S
				8'h57: c = 4'hA; // W
				8'h48: c = 4'hB; // H
				8'h42: c = 4'hC; // B
				8'h56: c = 4'hD; // V
				8'h44: c = 4'hE; // D
				default: c = 4'hF;
			endcase
			return c;
		end
	endfunction

endpackage

// ===== src/fasta_nibble_packer_core.sv =====
// The results of an accepted byte are registered in the result queue and leave it in order.
// Throughput: one byte per cycle while byte_ready is high; a byte that causes two results fills two queue slots.
// byte_ready is high while the four-entry result queue has at least two free slots.
// Reset (arst_n low, asynchronous) clears the parser state, the tallies and the queue.
// After a byte flagged final_byte the parser returns to its reset state.
module fasta_nibble_packer_core #(
	parameter int BASE_COUNT_BITS   = 40,
	parameter int RECORD_COUNT_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  fnp_pkg::in_item_t    byte_data,
	output logic                 res_valid,
	input  logic                 res_ready,
	output fnp_pkg::out_item_t   res_data
);

	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
	localparam logic [BASE_COUNT_BITS-1:0]   BASE_MAX = '1;
	localparam logic [RECORD_COUNT_BITS-1:0] REC_MAX  = '1;

	// Parser state.
	logic                         at_ls_q;
	logic                         in_hdr_q;
	logic                         in_rec_q;
	logic                         pend_v_q;
	logic [3:0]                   pend_c_q;
	logic [BASE_COUNT_BITS-1:0]   bases_q;
	logic [RECORD_COUNT_BITS-1:0] recs_q;

	logic                         at_ls_d;
	logic                         in_hdr_d;
	logic                         in_rec_d;
	logic                         pend_v_d;
	logic [3:0]                   pend_c_d;
	logic [BASE_COUNT_BITS-1:0]   bases_d;
	logic [RECORD_COUNT_BITS-1:0] recs_d;

	fnp_pkg::out_item_t           res0;
	fnp_pkg::out_item_t           res1;
	logic [1:0]                   nres;

	// Result queue.
	fnp_pkg::out_item_t           queue_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]          wr_q;
	logic [PTR_BITS-1:0]          rd_q;
	logic [CNT_BITS-1:0]          cnt_q;

	logic                         accept;
	logic                         pop;

	function automatic fnp_pkg::out_item_t make_result(
		input logic [1:0]                 kind,
		input logic [7:0]                 pbyte,
		input logic                       has,
		input logic [BASE_COUNT_BITS-1:0] bases,
		input logic [RECORD_COUNT_BITS-1:0] num
	);
		fnp_pkg::out_item_t r;
		logic [63:0] bases_w;
		logic [63:0] num_w;
		begin
			bases_w         = 64'(bases);
			num_w           = 64'(num);
			r.kind          = kind;
			r.packed_byte   = pbyte;
			r.has_byte      = has;
			r.record_bases  = bases_w[fnp_pkg::RESULT_BASES_BITS-1:0];
			r.record_number = num_w[fnp_pkg::RESULT_NUMBER_BITS-1:0];
			r.last_of_run   = 1'b0;
			return r;
		end
	endfunction

	assign accept     = byte_valid && byte_ready;
	assign pop        = res_valid && res_ready;
	assign byte_ready = cnt_q <= CNT_BITS'(QUEUE_DEPTH - 2);
	assign res_valid  = cnt_q != '0;
	assign res_data   = queue_q[rd_q];

	always_comb begin
		logic [7:0]                   b;
		logic                         fin;
		logic [3:0]                   code;
		logic [RECORD_COUNT_BITS-1:0] idx;
		fnp_pkg::out_item_t           r;
		b        = byte_data.in_byte;
		fin      = byte_data.final_byte;
		code     = fnp_pkg::iupac_code(b);
		at_ls_d  = at_ls_q;
		in_hdr_d = in_hdr_q;
		in_rec_d = in_rec_q;
		pend_v_d = pend_v_q;
		pend_c_d = pend_c_q;
		bases_d  = bases_q;
		recs_d   = recs_q;
		res0     = '0;
		res1     = '0;
		nres     = 2'd0;
		r        = '0;
		idx      = '0;

		if (in_hdr_q) begin
			if (b == fnp_pkg::CHAR_LF) begin
				in_hdr_d = 1'b0;
				at_ls_d  = 1'b1;
			end
		end else if (at_ls_q && b == fnp_pkg::CHAR_GT) begin
			if (in_rec_q) begin
				idx  = (recs_q == '0) ? '0 : recs_q - 1'b1;
				res0 = make_result(fnp_pkg::KIND_END, pend_v_q ? {pend_c_q, 4'h0} : 8'h00,
					pend_v_q, bases_q, idx);
				nres = 2'd1;
				in_rec_d = 1'b0;
				pend_v_d = 1'b0;
				pend_c_d = 4'h0;
				bases_d  = '0;
			end
			if (!fin) begin
				idx = (recs_q < REC_MAX) ? recs_q : REC_MAX - 1'b1;
				r   = make_result(fnp_pkg::KIND_START, 8'h00, 1'b0, '0, idx);
				if (nres == 2'd0) begin
					res0 = r;
				end else begin
					res1 = r;
				end
				nres = nres + 2'd1;
				if (recs_q < REC_MAX) begin
					recs_d = recs_q + 1'b1;
				end
				in_rec_d = 1'b1;
				in_hdr_d = 1'b1;
				pend_v_d = 1'b0;
				pend_c_d = 4'h0;
				bases_d  = '0;
			end
			at_ls_d = 1'b0;
		end else begin
			at_ls_d = (b == fnp_pkg::CHAR_LF);
			if (in_rec_q && !(b == fnp_pkg::CHAR_LF || b == fnp_pkg::CHAR_CR ||
					b == fnp_pkg::CHAR_SP || b == fnp_pkg::CHAR_TAB)) begin
				if (bases_q < BASE_MAX) begin
					bases_d = bases_q + 1'b1;
				end
				if (pend_v_q) begin
					res0 = make_result(fnp_pkg::KIND_DATA, {pend_c_q, code}, 1'b1, '0, '0);
					nres = 2'd1;
					pend_v_d = 1'b0;
					pend_c_d = 4'h0;
				end else begin
					pend_v_d = 1'b1;
					pend_c_d = code;
				end
			end
		end

		if (fin) begin
			// The record end sees the state left by this byte.
			if (in_rec_d) begin
				idx = (recs_d == '0) ? '0 : recs_d - 1'b1;
				r   = make_result(fnp_pkg::KIND_END, pend_v_d ? {pend_c_d, 4'h0} : 8'h00,
					pend_v_d, bases_d, idx);
				if (nres == 2'd0) begin
					res0 = r;
				end else begin
					res1 = r;
				end
				nres = nres + 2'd1;
			end
			at_ls_d  = 1'b1;
			in_hdr_d = 1'b0;
			in_rec_d = 1'b0;
			pend_v_d = 1'b0;
			pend_c_d = 4'h0;
			bases_d  = '0;
			recs_d   = '0;
		end

		if (nres == 2'd1) begin
			res0.last_of_run = 1'b1;
		end
		if (nres == 2'd2) begin
			res1.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_ls_q  <= 1'b1;
			in_hdr_q <= 1'b0;
			in_rec_q <= 1'b0;
			pend_v_q <= 1'b0;
			pend_c_q <= 4'h0;
			bases_q  <= '0;
			recs_q   <= '0;
		end else if (accept) begin
			at_ls_q  <= at_ls_d;
			in_hdr_q <= in_hdr_d;
			in_rec_q <= in_rec_d;
			pend_v_q <= pend_v_d;
			pend_c_q <= pend_c_d;
			bases_q  <= bases_d;
			recs_q   <= recs_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && nres != 2'd0) begin
			queue_q[wr_q] <= res0;
		end
		if (accept && nres == 2'd2) begin
			queue_q[wr_q + 1'b1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (accept) begin
				wr_q <= wr_q + PTR_BITS'(nres);
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (accept ? CNT_BITS'(nres) : '0) - (pop ? CNT_BITS'(1) : '0);
		end
	end

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(QUEUE_DEPTH))
		else $error("result queue count exceeds its depth");

	a_pending_in_record: assert property (@(posedge clk) disable iff (!arst_n)
		!in_rec_q |-> !pend_v_q)
		else $error("pending nibble held outside a record");

	a_header_in_record: assert property (@(posedge clk) disable iff (!arst_n)
		in_hdr_q |-> in_rec_q)
		else $error("header line skipped outside a record");

	a_final_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && byte_data.final_byte) |=> (at_ls_q && !in_rec_q && recs_q == '0))
		else $error("parser state not cleared after the final byte");
`endif

endmodule

// ===== test/fasta_nibble_packer_core_test.sv =====
`timescale 1ns / 100ps

module fasta_nibble_packer_core_test;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               byte_valid = 1'b0;
	logic               byte_ready;
	fnp_pkg::in_item_t  byte_data = '0;
	logic               res_valid;
	logic               res_ready = 1'b0;
	fnp_pkg::out_item_t res_data;

	fasta_nibble_packer_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data)
	);

	fnp_pkg::in_item_t  bytes_to_send[$];
	fnp_pkg::out_item_t results_due[$];

	int accepted_bytes = 0;
	int streams_closed = 0;
	int starts_seen = 0;
	int ends_seen = 0;
	int data_seen = 0;
	int fail_count = 0;

	// Parser state mirrored by the predictor.
	logic        line_head = 1'b1;
	logic        skipping_header = 1'b0;
	logic        record_open = 1'b0;
	logic        half_valid = 1'b0;
	logic [3:0]  half_code = 4'h0;
	logic [39:0] bases_in_record = '0;
	logic [31:0] record_count = '0;

	// Both sides run without idle cycles while this window of bytes is in flight.
	wire quiet_stretch = (accepted_bytes >= 700) && (accepted_bytes < 1000);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [3:0] nucleotide_nibble(input logic [7:0] ch);
		string      letters;
		logic [7:0] up;
		logic [3:0] code;
		letters = "-ACGTRYMKSWHBVD";
		up = (ch >= "a" && ch <= "z") ? ch - 8'h20 : ch;
		code = 4'hF;
		if (up == "U")
			code = 4'h4;
		for (int i = 0; i < 15; i++)
			if (letters[i] == up)
				code = i[3:0];
		return code;
	endfunction

	function automatic fnp_pkg::out_item_t close_record();
		fnp_pkg::out_item_t r;
		r = '0;
		r.kind = fnp_pkg::KIND_END;
		r.has_byte = half_valid;
		r.packed_byte = half_valid ? {half_code, 4'h0} : 8'h00;
		r.record_bases = bases_in_record;
		r.record_number = (record_count == 0) ? 32'd0 : record_count - 32'd1;
		record_open = 1'b0;
		half_valid = 1'b0;
		half_code = 4'h0;
		bases_in_record = '0;
		return r;
	endfunction

	function automatic void pack_fasta_byte(input fnp_pkg::in_item_t it);
		fnp_pkg::out_item_t res[2];
		fnp_pkg::out_item_t r;
		int                 n;
		logic [7:0]         b;
		logic [3:0]         c;
		n = 0;
		b = it.in_byte;
		if (skipping_header) begin
			if (b == fnp_pkg::CHAR_LF) begin
				skipping_header = 1'b0;
				line_head = 1'b1;
			end
		end else if (line_head && b == fnp_pkg::CHAR_GT) begin
			if (record_open) begin
				res[n] = close_record();
				n++;
			end
			// A header on the last byte of a stream opens nothing.
			if (!it.final_byte) begin
				r = '0;
				r.kind = fnp_pkg::KIND_START;
				r.record_number = (record_count != '1) ? record_count : record_count - 32'd1;
				res[n] = r;
				n++;
				if (record_count != '1)
					record_count++;
				record_open = 1'b1;
				skipping_header = 1'b1;
				half_valid = 1'b0;
				half_code = 4'h0;
				bases_in_record = '0;
			end
			line_head = 1'b0;
		end else begin
			line_head = (b == fnp_pkg::CHAR_LF);
			if (record_open && b != fnp_pkg::CHAR_LF && b != fnp_pkg::CHAR_CR &&
					b != fnp_pkg::CHAR_SP && b != fnp_pkg::CHAR_TAB) begin
				c = nucleotide_nibble(b);
				if (bases_in_record != '1)
					bases_in_record++;
				if (half_valid) begin
					r = '0;
					r.kind = fnp_pkg::KIND_DATA;
					r.packed_byte = {half_code, c};
					r.has_byte = 1'b1;
					res[n] = r;
					n++;
					half_valid = 1'b0;
					half_code = 4'h0;
				end else begin
					half_code = c;
					half_valid = 1'b1;
				end
			end
		end
		if (it.final_byte) begin
			if (record_open) begin
				res[n] = close_record();
				n++;
			end
			line_head = 1'b1;
			skipping_header = 1'b0;
			record_count = '0;
		end
		for (int i = 0; i < n; i++) begin
			res[i].last_of_run = (i == n - 1);
			results_due.insert(results_due.size(), res[i]);
		end
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// Driver: the predictor runs on every accepted transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_data <= '0;
		end else begin
			if (byte_valid && byte_ready) begin
				pack_fasta_byte(byte_data);
				accepted_bytes++;
				if (byte_data.final_byte)
					streams_closed++;
			end
			if (!byte_valid || byte_ready) begin
				if (bytes_to_send.size() != 0 && (quiet_stretch || $urandom_range(99) >= 11)) begin
					byte_data <= bytes_to_send.pop_front();
					byte_valid <= 1'b1;
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// One long hold-off on the result side so that the queue fills and stalls the input.
	int   stall_left = 0;
	logic hold_done = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
			end else if (!hold_done && accepted_bytes >= 400) begin
				stall_left <= 80;
				hold_done <= 1'b1;
			end
		end
	end

	// Monitor.
	always @(posedge clk or negedge arst_n) begin
		fnp_pkg::out_item_t want;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				if (results_due.size() == 0) begin
					note_failure($sformatf("unexpected result kind=%0d byte=%h has=%b bases=%0d num=%0d last=%b",
						res_data.kind, res_data.packed_byte, res_data.has_byte,
						res_data.record_bases, res_data.record_number, res_data.last_of_run));
				end else begin
					want = results_due.pop_front();
					case (res_data.kind)
						fnp_pkg::KIND_START: starts_seen++;
						fnp_pkg::KIND_END:   ends_seen++;
						default:             data_seen++;
					endcase
					if (res_data.kind !== want.kind || res_data.packed_byte !== want.packed_byte ||
						res_data.has_byte !== want.has_byte ||
						res_data.record_bases !== want.record_bases ||
						res_data.record_number !== want.record_number ||
						res_data.last_of_run !== want.last_of_run)
						note_failure($sformatf({"mismatch: expected kind=%0d byte=%h has=%b bases=%0d num=%0d last=%b",
							" got kind=%0d byte=%h has=%b bases=%0d num=%0d last=%b"},
							want.kind, want.packed_byte, want.has_byte, want.record_bases,
							want.record_number, want.last_of_run,
							res_data.kind, res_data.packed_byte, res_data.has_byte,
							res_data.record_bases, res_data.record_number, res_data.last_of_run));
				end
			end
			res_ready <= (stall_left == 0) && (quiet_stretch || $urandom_range(99) >= 11);
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic fin);
		fnp_pkg::in_item_t it;
		it.in_byte = b;
		it.final_byte = fin;
		bytes_to_send.insert(bytes_to_send.size(), it);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], 1'b0);
	endtask

	// One stretch of FASTA text: optional junk, a few records, mostly ending the stream.
	task automatic push_stream();
		string      alphabet;
		int         nrec;
		int         nlines;
		int         len;
		int         roll;
		logic [7:0] ch;
		alphabet = "ACGTUNRYMKSWHBVD-";
		if ($urandom_range(99) < 30)
			repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)), 1'b0);
		nrec = $urandom_range(1, 4);
		for (int r = 0; r < nrec; r++) begin
			if ($urandom_range(99) < 10)
				repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)), 1'b0);
			push_byte(fnp_pkg::CHAR_GT, 1'b0);
			repeat ($urandom_range(0, 6)) begin
				ch = 8'($urandom_range(255));
				push_byte((ch == fnp_pkg::CHAR_LF) ? 8'h78 : ch, 1'b0);
			end
			if ($urandom_range(99) >= 5)
				push_byte(fnp_pkg::CHAR_LF, 1'b0);
			nlines = $urandom_range(0, 3);
			for (int l = 0; l < nlines; l++) begin
				len = ($urandom_range(99) < 5) ? $urandom_range(1, 60) : $urandom_range(1, 20);
				for (int k = 0; k < len; k++) begin
					roll = $urandom_range(99);
					if (roll < 80) begin
						ch = alphabet[$urandom_range(alphabet.len() - 1)];
						if (ch >= "A" && ch <= "Z" && $urandom_range(1) == 1)
							ch = ch + 8'h20;
					end else if (roll < 88) begin
						case ($urandom_range(2))
							0:       ch = fnp_pkg::CHAR_SP;
							1:       ch = fnp_pkg::CHAR_TAB;
							default: ch = fnp_pkg::CHAR_CR;
						endcase
					end else if (roll < 92) begin
						ch = fnp_pkg::CHAR_GT;
					end else begin
						ch = 8'($urandom_range(255));
					end
					push_byte(ch, 1'b0);
				end
				push_byte(fnp_pkg::CHAR_LF, 1'b0);
			end
		end
		roll = $urandom_range(99);
		if (roll < 10)
			push_byte(fnp_pkg::CHAR_GT, 1'b1);
		else if (roll < 80)
			bytes_to_send[bytes_to_send.size() - 1].final_byte = 1'b1;
	endtask

	initial begin
		// Junk before the first header, whitespace, lowercase, a gap, an indented
		// '>', an odd flush, a header with no sequence closed by the stream end,
		// a fresh stream after it, and a '>' on the last byte with nothing open.
		push_byte(8'h41, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_text(">x\n");
		push_text("aC \t\r-g\n");
		push_byte(fnp_pkg::CHAR_SP, 1'b0);
		push_byte(fnp_pkg::CHAR_GT, 1'b0);
		push_byte(8'h00, 1'b0);
		push_text("n\n");
		push_text(">h\n");
		push_byte(fnp_pkg::CHAR_GT, 1'b1);
		push_text(">\nU");
		push_byte("t", 1'b1);
		push_byte(fnp_pkg::CHAR_GT, 1'b1);
		while (bytes_to_send.size() < 1550)
			push_stream();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_to_send.size() != 0 || byte_valid)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (results_due.size() != 0)
			note_failure($sformatf("%0d results never arrived", results_due.size()));
		$display("Fed %0d bytes over %0d closed streams with one long output stall.",
			accepted_bytes, streams_closed);
		$display("Checked %0d record starts, %0d record ends and %0d packed bytes; %0d failures.",
			starts_seen, ends_seen, data_seen, fail_count);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== fasta_nibble_packer_core.f =====
src/fnp_pkg.sv
src/fasta_nibble_packer_core.sv
test/fasta_nibble_packer_core_test.sv
